### rtl/sscg_pkg.sv
`default_nettype none

package sscg_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam logic signed [15:0] FORWARD_SPEED_THRESHOLD = 16'sd100;
  localparam logic signed [15:0] TURN_RATE_THRESHOLD = 16'sd200;

  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [INDEX_W-1:0] INDEX_CAP =
    INDEX_W'((MAX_SAMPLES - 1 > 1023) ? 1023 : MAX_SAMPLES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_ODOMETRY = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_WINDOW_START = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_WINDOW_MIDDLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_WINDOW_STOP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_WINDOW_LOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_WINDOW_HIGH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_HITS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_DISTANCE = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_DISTANCE = 3'd7;

  localparam int FLAG_FRONT = 0;
  localparam int FLAG_LEFT = 1;
  localparam int FLAG_RIGHT = 2;

  localparam logic [6:0] LIMIT_OPEN = 7'd100;
  localparam logic [6:0] LIMIT_BRAKE = 7'd0;
  localparam logic signed [7:0] LIMIT_REVERSE = -8'sd100;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] linear_speed_mm_s;
    logic signed [15:0] turn_rate_mrad_s;
    logic [15:0]        range_mm;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [6:0]        left_forward_limit;
    logic [6:0]        right_forward_limit;
    logic signed [7:0] left_reverse_limit;
    logic signed [7:0] right_reverse_limit;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/scan_sector_collision_guard.sv
// Collision guard for a wheeled robot.
//
// Input channel (in_valid / in_stall / in_data) carries three kinds of item:
// odometry updates set the motion flags, laser range samples are counted per
// index window, and evaluation ticks engage or release the brake. An item is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_data) carries velocity limits,
// one item per tick that changes the brake state; other items give none.
//
// Throughput: one item per cycle while in_stall is low; every item is decoded
// and applied in the cycle it is taken. A tick's result is registered in the
// output register, or in the skid register when the receiver stalls.
// When the receiver stalls, the held result stays in the output register and
// one more result fits in a skid register; in_stall rises only while the skid
// register is full, and falls the cycle after the receiver takes an item.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered; the
// user must make them while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) loads the register defaults, clears the counters,
// flags and brake state, and empties both output registers; no clearing pass.
`default_nettype none

module scan_sector_collision_guard (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire sscg_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output sscg_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_write,
  input  wire logic [sscg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [sscg_pkg::CFG_W-1:0]           cfg_data
);

  localparam int IW = sscg_pkg::INDEX_W;
  localparam int CW = sscg_pkg::COUNT_W;

  logic [IW-1:0] side_window_start;
  logic [IW-1:0] side_window_middle;
  logic [IW-1:0] side_window_stop;
  logic [IW-1:0] front_window_low;
  logic [IW-1:0] front_window_high;
  logic [CW-1:0] min_hits;
  logic [15:0]   side_distance_mm;
  logic [15:0]   front_distance_mm;

  logic [IW-1:0] sample_index, sample_index_next;
  logic [CW-1:0] left_count, left_count_next;
  logic [CW-1:0] right_count, right_count_next;
  logic [CW-1:0] front_count, front_count_next;
  logic [2:0]    motion_flags, motion_flags_next;
  logic [2:0]    obstacle_flags, obstacle_flags_next;
  logic          brake_active, brake_active_next;

  logic                accept;
  logic                res_fire;
  sscg_pkg::out_item_t res;
  logic                skid_valid;
  sscg_pkg::out_item_t skid_data;
  logic                out_free;
  logic                danger;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c < sscg_pkg::COUNT_MAX) ? c + CW'(1) : c;
  endfunction

  function automatic logic between(input logic [IW-1:0] i, input logic [IW-1:0] lo,
                                   input logic [IW-1:0] hi);
    return (i > lo) && (i < hi);
  endfunction

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign danger   = |(obstacle_flags & motion_flags);

  always_comb begin
    sample_index_next   = sample_index;
    left_count_next     = left_count;
    right_count_next    = right_count;
    front_count_next    = front_count;
    motion_flags_next   = motion_flags;
    obstacle_flags_next = obstacle_flags;
    brake_active_next   = brake_active;
    res_fire            = 1'b0;
    res.left_forward_limit  = sscg_pkg::LIMIT_BRAKE;
    res.right_forward_limit = sscg_pkg::LIMIT_BRAKE;
    res.left_reverse_limit  = sscg_pkg::LIMIT_REVERSE;
    res.right_reverse_limit = sscg_pkg::LIMIT_REVERSE;
    if (accept) begin
      case (in_data.op)
        sscg_pkg::OP_ODOMETRY: begin
          motion_flags_next[sscg_pkg::FLAG_FRONT] =
            in_data.linear_speed_mm_s > sscg_pkg::FORWARD_SPEED_THRESHOLD;
          motion_flags_next[sscg_pkg::FLAG_LEFT] =
            in_data.turn_rate_mrad_s > sscg_pkg::TURN_RATE_THRESHOLD;
          motion_flags_next[sscg_pkg::FLAG_RIGHT] =
            in_data.turn_rate_mrad_s < -sscg_pkg::TURN_RATE_THRESHOLD;
        end
        sscg_pkg::OP_SAMPLE: begin
          if (in_data.range_mm < side_distance_mm) begin
            if (between(sample_index, side_window_start, side_window_middle)) begin
              left_count_next = bump(left_count);
            end
            if (between(sample_index, side_window_middle, side_window_stop)) begin
              right_count_next = bump(right_count);
            end
          end
          if (in_data.range_mm < front_distance_mm &&
              between(sample_index, front_window_low, front_window_high)) begin
            front_count_next = bump(front_count);
          end
          if (in_data.last_sample) begin
            obstacle_flags_next[sscg_pkg::FLAG_FRONT] = front_count_next >= min_hits;
            obstacle_flags_next[sscg_pkg::FLAG_LEFT]  = left_count_next >= min_hits;
            obstacle_flags_next[sscg_pkg::FLAG_RIGHT] = right_count_next >= min_hits;
            left_count_next   = '0;
            right_count_next  = '0;
            front_count_next  = '0;
            sample_index_next = '0;
          end else if (sample_index < sscg_pkg::INDEX_CAP) begin
            sample_index_next = sample_index + IW'(1);
          end
        end
        sscg_pkg::OP_TICK: begin
          if (danger && !brake_active) begin
            brake_active_next = 1'b1;
            res_fire = 1'b1;
          end else if (!danger && brake_active) begin
            brake_active_next = 1'b0;
            res_fire = 1'b1;
            res.left_forward_limit  = sscg_pkg::LIMIT_OPEN;
            res.right_forward_limit = sscg_pkg::LIMIT_OPEN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_window_start  <= IW'(189);
      side_window_middle <= IW'(270);
      side_window_stop   <= IW'(351);
      front_window_low   <= IW'(232);
      front_window_high  <= IW'(308);
      min_hits           <= CW'(27);
      side_distance_mm   <= 16'd200;
      front_distance_mm  <= 16'd200;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sscg_pkg::REG_SIDE_WINDOW_START:  side_window_start  <= cfg_data[IW-1:0];
        sscg_pkg::REG_SIDE_WINDOW_MIDDLE: side_window_middle <= cfg_data[IW-1:0];
        sscg_pkg::REG_SIDE_WINDOW_STOP:   side_window_stop   <= cfg_data[IW-1:0];
        sscg_pkg::REG_FRONT_WINDOW_LOW:   front_window_low   <= cfg_data[IW-1:0];
        sscg_pkg::REG_FRONT_WINDOW_HIGH:  front_window_high  <= cfg_data[IW-1:0];
        sscg_pkg::REG_MIN_HITS:           min_hits           <= cfg_data[CW-1:0];
        sscg_pkg::REG_SIDE_DISTANCE:      side_distance_mm   <= cfg_data[15:0];
        sscg_pkg::REG_FRONT_DISTANCE:     front_distance_mm  <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= '0;
      left_count     <= '0;
      right_count    <= '0;
      front_count    <= '0;
      motion_flags   <= '0;
      obstacle_flags <= '0;
      brake_active   <= 1'b0;
    end else begin
      sample_index   <= sample_index_next;
      left_count     <= left_count_next;
      right_count    <= right_count_next;
      front_count    <= front_count_next;
      motion_flags   <= motion_flags_next;
      obstacle_flags <= obstacle_flags_next;
      brake_active   <= brake_active_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_fire) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (res_fire) begin
      if (out_free) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sscg_checker.sv
`default_nettype none

module sscg_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire sscg_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_limits_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.left_forward_limit == out_data.right_forward_limit &&
      (out_data.left_forward_limit == sscg_pkg::LIMIT_BRAKE ||
       out_data.left_forward_limit == sscg_pkg::LIMIT_OPEN) &&
      out_data.left_reverse_limit == sscg_pkg::LIMIT_REVERSE &&
      out_data.right_reverse_limit == sscg_pkg::LIMIT_REVERSE)
    else $error("bad velocity limits");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind scan_sector_collision_guard sscg_checker u_sscg_checker (.*);

`default_nettype wire

### verif/scan_sector_collision_guard_checker.sv
`default_nettype none

module scan_sector_collision_guard_checker
  import sscg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire in_item_t               in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire out_item_t              out_data,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  output int                          mismatches,
  output int                          expected_left
);

  logic [INDEX_W-1:0] win_side_start;
  logic [INDEX_W-1:0] win_side_middle;
  logic [INDEX_W-1:0] win_side_stop;
  logic [INDEX_W-1:0] win_front_low;
  logic [INDEX_W-1:0] win_front_high;
  logic [COUNT_W-1:0] hits_needed;
  logic [15:0]        side_dist;
  logic [15:0]        front_dist;

  logic [INDEX_W-1:0] scan_pos;
  logic [COUNT_W-1:0] left_hits;
  logic [COUNT_W-1:0] right_hits;
  logic [COUNT_W-1:0] front_hits;
  logic [2:0]         moving;
  logic [2:0]         blocked;
  logic               braking;

  out_item_t limits_due[$];
  out_item_t want;

  function automatic logic [COUNT_W-1:0] saturate_inc(logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

  function automatic logic between(logic [INDEX_W-1:0] i, logic [INDEX_W-1:0] lo,
                                   logic [INDEX_W-1:0] hi);
    return i > lo && i < hi;
  endfunction

  task automatic push_limits(logic [6:0] fwd);
    out_item_t lim;
    lim.left_forward_limit = fwd;
    lim.right_forward_limit = fwd;
    lim.left_reverse_limit = LIMIT_REVERSE;
    lim.right_reverse_limit = LIMIT_REVERSE;
    limits_due.push_back(lim);
  endtask

  task automatic apply_item(in_item_t it);
    logic [INDEX_W-1:0] pos;
    logic               danger;
    int                 speed;
    int                 turn;
    case (it.op)
      OP_ODOMETRY: begin
        speed = int'($signed(it.linear_speed_mm_s));
        turn = int'($signed(it.turn_rate_mrad_s));
        moving = '0;
        moving[FLAG_FRONT] = speed > int'(FORWARD_SPEED_THRESHOLD);
        moving[FLAG_LEFT] = turn > int'(TURN_RATE_THRESHOLD);
        moving[FLAG_RIGHT] = turn < -int'(TURN_RATE_THRESHOLD);
      end
      OP_SAMPLE: begin
        pos = scan_pos;
        if (it.range_mm < side_dist) begin
          if (between(pos, win_side_start, win_side_middle)) left_hits = saturate_inc(left_hits);
          if (between(pos, win_side_middle, win_side_stop)) right_hits = saturate_inc(right_hits);
        end
        if (it.range_mm < front_dist && between(pos, win_front_low, win_front_high))
          front_hits = saturate_inc(front_hits);
        if (it.last_sample) begin
          blocked = '0;
          blocked[FLAG_FRONT] = front_hits >= hits_needed;
          blocked[FLAG_LEFT] = left_hits >= hits_needed;
          blocked[FLAG_RIGHT] = right_hits >= hits_needed;
          left_hits = '0;
          right_hits = '0;
          front_hits = '0;
          scan_pos = '0;
        end else if (scan_pos < INDEX_CAP) begin
          scan_pos = scan_pos + INDEX_W'(1);
        end
      end
      OP_TICK: begin
        danger = |(blocked & moving);
        if (danger && !braking) begin
          braking = 1'b1;
          push_limits(LIMIT_BRAKE);
        end else if (!danger && braking) begin
          braking = 1'b0;
          push_limits(LIMIT_OPEN);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_side_start = 10'd189;
      win_side_middle = 10'd270;
      win_side_stop = 10'd351;
      win_front_low = 10'd232;
      win_front_high = 10'd308;
      hits_needed = 11'd27;
      side_dist = 16'd200;
      front_dist = 16'd200;
      scan_pos = '0;
      left_hits = '0;
      right_hits = '0;
      front_hits = '0;
      moving = '0;
      blocked = '0;
      braking = 1'b0;
      limits_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SIDE_WINDOW_START:  win_side_start = cfg_data[INDEX_W-1:0];
          REG_SIDE_WINDOW_MIDDLE: win_side_middle = cfg_data[INDEX_W-1:0];
          REG_SIDE_WINDOW_STOP:   win_side_stop = cfg_data[INDEX_W-1:0];
          REG_FRONT_WINDOW_LOW:   win_front_low = cfg_data[INDEX_W-1:0];
          REG_FRONT_WINDOW_HIGH:  win_front_high = cfg_data[INDEX_W-1:0];
          REG_MIN_HITS:           hits_needed = cfg_data[COUNT_W-1:0];
          REG_SIDE_DISTANCE:      side_dist = cfg_data;
          REG_FRONT_DISTANCE:     front_dist = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_item(in_data);
      if (out_valid && !out_stall) begin
        if (limits_due.size() == 0) begin
          $display("%0t: limits expected none, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = limits_due.pop_front();
          check_field("left_forward_limit", int'(want.left_forward_limit),
                      int'(out_data.left_forward_limit));
          check_field("right_forward_limit", int'(want.right_forward_limit),
                      int'(out_data.right_forward_limit));
          check_field("left_reverse_limit", int'(want.left_reverse_limit),
                      int'(out_data.left_reverse_limit));
          check_field("right_reverse_limit", int'(want.right_reverse_limit),
                      int'(out_data.right_reverse_limit));
        end
      end
    end
    expected_left <= limits_due.size();
  end

endmodule

`default_nettype wire

### verif/tb_scan_sector_collision_guard.sv
`default_nettype none

module tb_scan_sector_collision_guard;
  import sscg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int   mismatches;
  int   expected_left;
  logic steady = 1'b0;
  int   hold_seq = 0;
  int   items_sent = 0;
  logic [CFG_W-1:0] cfg_val [8];

  scan_sector_collision_guard dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scan_sector_collision_guard_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .expected_left(expected_left)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall per item, one long hold-off per request
  initial begin
    int n;
    int hold_seen;
    hold_seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 4);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        n = 300;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t odometry_item(int speed, int turn);
    in_item_t it;
    it.op = OP_ODOMETRY;
    it.linear_speed_mm_s = speed[15:0];
    it.turn_rate_mrad_s = turn[15:0];
    it.range_mm = 16'($urandom);
    it.last_sample = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t sample_item(int range, logic last);
    in_item_t it;
    it.op = OP_SAMPLE;
    it.linear_speed_mm_s = 16'($urandom);
    it.turn_rate_mrad_s = 16'($urandom);
    it.range_mm = range[15:0];
    it.last_sample = last;
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [1:0] op = OP_TICK);
    in_item_t it;
    it.op = op;
    it.linear_speed_mm_s = 16'($urandom);
    it.turn_rate_mrad_s = 16'($urandom);
    it.range_mm = 16'($urandom);
    it.last_sample = 1'($urandom);
    return it;
  endfunction

  function automatic int pick_speed();
    case ($urandom_range(0, 3))
      0: return $urandom_range(90, 110);
      1: return -int'($urandom_range(0, 300));
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_turn();
    case ($urandom_range(0, 4))
      0: return $urandom_range(190, 210);
      1: return -int'($urandom_range(190, 210));
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      3: return $urandom_range(0, 50);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_range();
    int near_mm;
    near_mm = $urandom_range(0, 1) ? int'(cfg_val[REG_SIDE_DISTANCE]) :
                                     int'(cfg_val[REG_FRONT_DISTANCE]);
    case ($urandom_range(0, 5))
      0, 1, 2: return (near_mm > 0) ? $urandom_range(0, near_mm - 1) : 0;
      3: return near_mm;
      4: return $urandom_range(0, 1) ? 0 : 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  // drop valid and wait until every expected result is out and the block is quiet
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((expected_left != 0 || waited < 4) && waited < 20000);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_defaults();
    cfg_val[REG_SIDE_WINDOW_START] = 16'd189;
    cfg_val[REG_SIDE_WINDOW_MIDDLE] = 16'd270;
    cfg_val[REG_SIDE_WINDOW_STOP] = 16'd351;
    cfg_val[REG_FRONT_WINDOW_LOW] = 16'd232;
    cfg_val[REG_FRONT_WINDOW_HIGH] = 16'd308;
    cfg_val[REG_MIN_HITS] = 16'd27;
    cfg_val[REG_SIDE_DISTANCE] = 16'd200;
    cfg_val[REG_FRONT_DISTANCE] = 16'd200;
  endtask

  task automatic apply_config();
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data <= cfg_val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_config(int p);
    int s;
    int m;
    int f;
    s = $urandom_range(0, 20);
    m = s + $urandom_range(0, 25);
    f = $urandom_range(0, 30);
    cfg_val[REG_SIDE_WINDOW_START] = CFG_W'(s);
    cfg_val[REG_SIDE_WINDOW_MIDDLE] = CFG_W'(m);
    cfg_val[REG_SIDE_WINDOW_STOP] = CFG_W'(m + $urandom_range(0, 25));
    cfg_val[REG_FRONT_WINDOW_LOW] = CFG_W'(f);
    cfg_val[REG_FRONT_WINDOW_HIGH] = CFG_W'(f + $urandom_range(0, 30));
    if ($urandom_range(0, 5) == 0) begin
      cfg_val[REG_FRONT_WINDOW_LOW] = cfg_val[REG_FRONT_WINDOW_HIGH];
      cfg_val[REG_FRONT_WINDOW_HIGH] = CFG_W'(f);
    end
    if ($urandom_range(0, 5) == 0) begin
      cfg_val[REG_SIDE_WINDOW_START] = cfg_val[REG_SIDE_WINDOW_STOP];
      cfg_val[REG_SIDE_WINDOW_STOP] = CFG_W'(s);
    end
    cfg_val[REG_MIN_HITS] = CFG_W'($urandom_range(0, 10));
    cfg_val[REG_SIDE_DISTANCE] = CFG_W'($urandom_range(50, 3000));
    cfg_val[REG_FRONT_DISTANCE] = CFG_W'($urandom_range(50, 3000));
    case (p % 4)
      1: begin
        cfg_val[REG_MIN_HITS] = '0;
        cfg_val[REG_SIDE_DISTANCE] = '0;
        cfg_val[REG_FRONT_DISTANCE] = '0;
      end
      3: begin
        cfg_val[REG_SIDE_WINDOW_START] = '0;
        cfg_val[REG_SIDE_WINDOW_STOP] = CFG_W'(1023);
        cfg_val[REG_FRONT_WINDOW_LOW] = '0;
        cfg_val[REG_FRONT_WINDOW_HIGH] = CFG_W'(1023);
        cfg_val[REG_SIDE_DISTANCE] = '1;
        cfg_val[REG_FRONT_DISTANCE] = '1;
      end
      default: ;
    endcase
  endtask

  task automatic send_scan(int len, logic finish);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) send_item(odometry_item(pick_speed(), pick_turn()));
      else if ($urandom_range(0, 15) == 0) send_item(tick_item());
      send_item(sample_item(pick_range(), finish && k == len - 1));
    end
  endtask

  task automatic directed_items();
    send_item(tick_item());
    send_item(tick_item(OP_UNUSED));
    send_item(odometry_item(32767, 32767));
    send_item(odometry_item(-32768, -32768));
    send_item(odometry_item(100, 200));
    send_item(odometry_item(101, 201));
    send_item(odometry_item(0, -200));
    send_item(odometry_item(0, -201));
    send_item(sample_item(0, 1'b0));
    send_item(sample_item(65535, 1'b1));
    send_item(tick_item());
    settle();
    load_defaults();
    cfg_val[REG_MIN_HITS] = '0;
    apply_config();
    send_item(sample_item(65535, 1'b1));
    send_item(odometry_item(101, 0));
    send_item(tick_item());
    send_item(tick_item());
    send_item(odometry_item(0, 0));
    send_item(tick_item());
    send_item(odometry_item(0, 201));
    send_item(tick_item());
    send_item(odometry_item(-1, -32768));
    send_item(tick_item());
    send_item(tick_item(OP_UNUSED));
    send_item(odometry_item(0, 0));
    send_item(tick_item());
  endtask

  // every tick toggles the brake, so a held receiver backs the block up
  task automatic pressure_phase();
    settle();
    steady <= 1'b0;
    hold_seq <= hold_seq + 1;
    send_item(sample_item(65535, 1'b1));
    for (int k = 0; k < 10; k++) begin
      send_item(odometry_item(500, 0));
      send_item(tick_item());
      send_item(odometry_item(0, 0));
      send_item(tick_item());
    end
  endtask

  task automatic random_phase(int p);
    int first;
    settle();
    randomize_config(p);
    apply_config();
    steady <= (p % 3 == 2);
    first = items_sent;
    while (items_sent - first < 25) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_scan($urandom_range(1, 40), 1'b1);
        4: send_scan($urandom_range(1, 12), $urandom_range(0, 1));
        5, 6: send_item(odometry_item(pick_speed(), pick_turn()));
        7, 8: send_item(tick_item());
        default: send_item(tick_item($urandom_range(0, 1) ? OP_UNUSED : OP_TICK));
      endcase
    end
  endtask

  // over-long scan: close samples past the index cap must not be counted
  task automatic long_scan_phase();
    settle();
    cfg_val[REG_SIDE_WINDOW_START] = '0;
    cfg_val[REG_SIDE_WINDOW_MIDDLE] = CFG_W'(1023);
    cfg_val[REG_SIDE_WINDOW_STOP] = CFG_W'(1023);
    cfg_val[REG_FRONT_WINDOW_LOW] = '0;
    cfg_val[REG_FRONT_WINDOW_HIGH] = CFG_W'(1023);
    cfg_val[REG_MIN_HITS] = CFG_W'(1);
    cfg_val[REG_SIDE_DISTANCE] = '1;
    cfg_val[REG_FRONT_DISTANCE] = '1;
    apply_config();
    steady <= 1'b1;
    send_item(odometry_item(500, 300));
    send_item(tick_item());
    for (int k = 0; k < 1030; k++)
      send_item(sample_item((k < 1024) ? 65535 : 0, k == 1029));
    send_item(tick_item());
    for (int k = 0; k < 10; k++) send_item(sample_item(0, k == 9));
    send_item(tick_item());
    settle();
    cfg_val[REG_MIN_HITS] = CFG_W'(1024);
    apply_config();
    for (int k = 0; k < 10; k++) send_item(sample_item(0, k == 9));
    send_item(tick_item());
    steady <= 1'b0;
  endtask

  initial begin
    load_defaults();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    pressure_phase();
    for (int p = 0; p < 4; p++) random_phase(p);
    long_scan_phase();
    settle();
    if (mismatches == 0 && expected_left == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
